FILE: rtl/core/lbmp_pkg.sv
// shared constants, register codes and helpers for the line-buffered max pool
package lbmp_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int WINDOW_DIM_DEF  = 2;
  localparam int MAX_COLUMNS_DEF = 64;
  localparam int PAIRS_DEF       = 8;

  localparam int CFG_BITS       = 7;
  localparam int CFG_INDEX_BITS = 3;
  localparam int STRIDE_BITS    = 2;
  // scan position: up to 127 outputs times stride 3
  localparam int POS_BITS       = 9;
  // keep, strobe, user, ident, route from the lowest bit up
  localparam int SIDE_BITS      = 11;

  localparam logic [CFG_BITS-1:0]    OUT_WIDTH_RST  = 7'd32;
  localparam logic [CFG_BITS-1:0]    OUT_HEIGHT_RST = 7'd32;
  localparam logic [STRIDE_BITS-1:0] STRIDE_RST     = 2'd2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_IN_WIDTH   = 3'd0,
    REG_IN_HEIGHT  = 3'd1,
    REG_OUT_WIDTH  = 3'd2,
    REG_OUT_HEIGHT = 3'd3,
    REG_STRIDE     = 3'd4
  } cfg_reg_t;

  // position modulo 3 by summing base-4 digits
  function automatic logic [1:0] mod3(input logic [POS_BITS-1:0] pos);
    logic [3:0] dsum;
    logic [2:0] r;
    dsum = 4'(pos[1:0]) + 4'(pos[3:2]) + 4'(pos[5:4]) + 4'(pos[7:6]) + 4'(pos[8]);
    r = 3'(dsum[1:0]) + 3'(dsum[3:2]);
    if (r >= 3'd3) r = r - 3'd3;
    if (r >= 3'd3) r = r - 3'd3;
    return r[1:0];
  endfunction

  // true when pos sits on the last phase of the stride
  function automatic logic phase_end(input logic [POS_BITS-1:0] pos,
                                     input logic [STRIDE_BITS-1:0] s);
    logic res;
    case (s)
      2'd2:    res = pos[0];
      2'd3:    res = (mod3(pos) == 2'd2);
      default: res = 1'b1;
    endcase
    return res;
  endfunction

endpackage

FILE: rtl/core/line_buffer_max_pool.sv
// line-buffered 2-d max pool over a stream of channel pairs, two samples per beat
// a beat that closes a window is registered in the compute stage, and its result queued for m_axis
// throughput: one beat per cycle while the result queue has room; line store and column
//   history rams are read at accept and written back the next cycle, with forwarding
//   when the next beat hits the same entry
// reset: rst clears scan position, sideband hold and the result queue and loads config defaults;
//   ram contents stay undefined until the scan writes them
module line_buffer_max_pool
  import lbmp_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int WINDOW_DIM  = WINDOW_DIM_DEF,
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int PAIRS       = PAIRS_DEF,
  localparam int FIELD_W    = 2*SAMPLE_BITS + SIDE_BITS,
  localparam int TDATA_W    = ((FIELD_W + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // value_a, value_b, keep_in, strobe_in, user_in, ident_in, route_in, zero fill
  input  logic [TDATA_W-1:0]        s_axis_tdata,
  // req_type
  input  logic                      s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // max_a, max_b, keep_out, strobe_out, user_out, ident_out, route_out, zero fill
  output logic [TDATA_W-1:0]        m_axis_tdata,
  // frame_end
  output logic                      m_axis_tlast
);

  localparam int SB      = SAMPLE_BITS;
  localparam int K       = WINDOW_DIM;
  localparam int PB      = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int CB      = $clog2(MAX_COLUMNS);
  localparam int LINE_AW = PB + CB;
  localparam int LINE_W  = 2*K*SB;
  localparam int HIST_W  = 2*(K-1)*SB;
  localparam int RES_W   = FIELD_W + 1;
  localparam logic [SB-1:0] NEG_FP_MAX = {1'b1, {(SB-2){1'b0}}, 1'b1};

  // configuration
  logic [CFG_BITS-1:0]    out_width;
  logic [CFG_BITS-1:0]    out_height;
  logic [STRIDE_BITS-1:0] stride;
  logic [STRIDE_BITS-1:0] eff_stride;
  logic [POS_BITS:0]      col_lim;
  logic [POS_BITS:0]      row_lim;

  // scan position
  logic [POS_BITS-1:0]  scan_row;
  logic [POS_BITS-1:0]  scan_col;
  logic [PB-1:0]        pair_index;
  logic [CB-1:0]        col_addr;
  logic [SIDE_BITS-1:0] side_hold;

  logic                 accept;
  logic                 last_pair;
  logic                 col_wrap;
  logic                 row_wrap;
  logic                 emit;
  logic                 fin;
  logic [SIDE_BITS-1:0] side_next;
  logic [SB-1:0]        va_in;
  logic [SB-1:0]        vb_in;
  logic [LINE_AW-1:0]   line_raddr;

  // compute stage
  logic                 s1_valid;
  logic                 s1_emit;
  logic                 s1_fin;
  logic [SB-1:0]        s1_va;
  logic [SB-1:0]        s1_vb;
  logic [SIDE_BITS-1:0] s1_side;
  logic [LINE_AW-1:0]   s1_line_addr;
  logic [PB-1:0]        s1_pair;
  logic                 s1_fwd_line;
  logic                 s1_fwd_hist;
  logic [LINE_W-1:0]    line_last;
  logic [HIST_W-1:0]    hist_last;

  logic [LINE_W-1:0]    line_rdata;
  logic [HIST_W-1:0]    hist_rdata;
  logic [LINE_W-1:0]    line_cur;
  logic [HIST_W-1:0]    hist_cur;
  logic [LINE_W-1:0]    line_new;
  logic [HIST_W-1:0]    hist_new;
  logic signed [SB-1:0] col_a;
  logic signed [SB-1:0] col_b;
  logic signed [SB-1:0] win_a;
  logic signed [SB-1:0] win_b;

  // output side
  logic             q_push;
  logic             q_pop;
  logic [1:0]       q_count;
  logic [2:0]       q_occ;
  logic [RES_W-1:0] q_head;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      out_width  <= OUT_WIDTH_RST;
      out_height <= OUT_HEIGHT_RST;
      stride     <= STRIDE_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IN_WIDTH,
        REG_IN_HEIGHT: begin
          // real map extent comes with the beats as pad ticks; nothing to hold
        end
        REG_OUT_WIDTH:  out_width  <= cfg_data;
        REG_OUT_HEIGHT: out_height <= cfg_data;
        REG_STRIDE:     stride     <= cfg_data[STRIDE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign eff_stride = (stride == '0) ? STRIDE_BITS'(1) : stride;
  assign col_lim    = (POS_BITS+1)'(out_width) * (POS_BITS+1)'(eff_stride);
  assign row_lim    = (POS_BITS+1)'(out_height) * (POS_BITS+1)'(eff_stride);

  // ---------------------------------------------------------------- accept side
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign last_pair = (pair_index == PB'(PAIRS - 1));
  assign col_wrap  = ((POS_BITS+1)'(scan_col) + 1'b1) >= col_lim;
  assign row_wrap  = ((POS_BITS+1)'(scan_row) + 1'b1) >= row_lim;

  assign emit = (scan_row >= POS_BITS'(K - 1)) && (scan_col >= POS_BITS'(K - 1)) &&
                phase_end(scan_row, eff_stride) && phase_end(scan_col, eff_stride);
  assign fin  = (((POS_BITS+1)'(scan_row) + 1'b1) == row_lim) &&
                (((POS_BITS+1)'(scan_col) + 1'b1) == col_lim) && last_pair;

  // pad ticks carry -max and leave the sideband alone
  assign side_next  = s_axis_tuser ? side_hold : s_axis_tdata[2*SB +: SIDE_BITS];
  assign va_in      = s_axis_tuser ? NEG_FP_MAX : s_axis_tdata[0 +: SB];
  assign vb_in      = s_axis_tuser ? NEG_FP_MAX : s_axis_tdata[SB +: SB];
  assign line_raddr = {pair_index, col_addr};

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_row   <= '0;
      scan_col   <= '0;
      pair_index <= '0;
      col_addr   <= '0;
      side_hold  <= '0;
    end else if (accept) begin
      side_hold <= side_next;
      if (!last_pair) begin
        pair_index <= pair_index + 1'b1;
      end else begin
        pair_index <= '0;
        if (col_wrap) begin
          scan_col <= '0;
          col_addr <= '0;
          scan_row <= row_wrap ? '0 : scan_row + 1'b1;
        end else begin
          scan_col <= scan_col + 1'b1;
          col_addr <= (col_addr == CB'(MAX_COLUMNS - 1)) ? '0 : col_addr + 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------- memories
  lbmp_ram #(
    .WIDTH (LINE_W),
    .DEPTH (2**LINE_AW)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_line_addr),
    .wdata (line_new),
    .re    (accept),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

  // last K-1 column maxima of each pair
  lbmp_ram #(
    .WIDTH (HIST_W),
    .DEPTH (2**PB)
  ) u_hist_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_pair),
    .wdata (hist_new),
    .re    (accept),
    .raddr (pair_index),
    .rdata (hist_rdata)
  );

  // ---------------------------------------------------------------- compute stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_emit  <= 1'b0;
    end else begin
      s1_valid <= accept;
      s1_emit  <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_fin       <= fin;
      s1_va        <= va_in;
      s1_vb        <= vb_in;
      s1_side      <= side_next;
      s1_line_addr <= line_raddr;
      s1_pair      <= pair_index;
      // the write of the beat in flight lands at this edge, after the read
      s1_fwd_line  <= s1_valid && (s1_line_addr == line_raddr);
      s1_fwd_hist  <= s1_valid && (s1_pair == pair_index);
    end
    if (s1_valid) begin
      line_last <= line_new;
      hist_last <= hist_new;
    end
  end

  assign line_cur = s1_fwd_line ? line_last : line_rdata;
  assign hist_cur = s1_fwd_hist ? hist_last : hist_rdata;

  always_comb begin
    // shift the new samples into the column, oldest row at the bottom
    line_new = line_cur;
    for (int r = 0; r < K - 1; r++) begin
      line_new[r*SB +: SB]     = line_cur[(r+1)*SB +: SB];
      line_new[(K+r)*SB +: SB] = line_cur[(K+r+1)*SB +: SB];
    end
    line_new[(K-1)*SB +: SB]   = s1_va;
    line_new[(2*K-1)*SB +: SB] = s1_vb;

    col_a = NEG_FP_MAX;
    col_b = NEG_FP_MAX;
    for (int r = 0; r < K; r++) begin
      if ($signed(line_new[r*SB +: SB]) > col_a) col_a = line_new[r*SB +: SB];
      if ($signed(line_new[(K+r)*SB +: SB]) > col_b) col_b = line_new[(K+r)*SB +: SB];
    end

    hist_new = hist_cur;
    for (int j = 1; j < K - 1; j++) begin
      hist_new[j*SB +: SB]       = hist_cur[(j-1)*SB +: SB];
      hist_new[(K-1+j)*SB +: SB] = hist_cur[(K-2+j)*SB +: SB];
    end
    hist_new[0 +: SB]        = col_a;
    hist_new[(K-1)*SB +: SB] = col_b;

    win_a = col_a;
    win_b = col_b;
    for (int j = 0; j < K - 1; j++) begin
      if ($signed(hist_cur[j*SB +: SB]) > win_a) win_a = hist_cur[j*SB +: SB];
      if ($signed(hist_cur[(K-1+j)*SB +: SB]) > win_b) win_b = hist_cur[(K-1+j)*SB +: SB];
    end
  end

  // ---------------------------------------------------------------- output side
  assign q_push = s1_valid && s1_emit;
  assign q_pop  = m_axis_tvalid && m_axis_tready;
  assign q_occ  = 3'(q_count) + 3'(q_push) - 3'(q_pop);

  // room for the beat in flight and for the one taken now
  assign s_axis_tready = !rst && (q_occ <= 3'd1);

  lbmp_out_queue #(
    .WIDTH (RES_W)
  ) u_out_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  ({s1_fin, s1_side, win_b, win_a}),
    .pop        (q_pop),
    .head_valid (m_axis_tvalid),
    .head_data  (q_head),
    .count      (q_count)
  );

  assign m_axis_tdata = {{(TDATA_W-FIELD_W){1'b0}}, q_head[FIELD_W-1:0]};
  assign m_axis_tlast = q_head[FIELD_W];

  // ---------------------------------------------------------------- checks
  a_stage_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted beat did not reach the compute stage");

  a_pair_range: assert property (@(posedge clk) disable iff (rst)
    pair_index <= PB'(PAIRS - 1))
    else $error("pair index beyond pair count");

  a_fwd_source: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && (s1_fwd_line || s1_fwd_hist)) |-> $past(s1_valid))
    else $error("forwarding without a preceding write");

endmodule

FILE: rtl/core/lbmp_ram.sv
// generic single-write, single-read ram with registered read data
module lbmp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/lbmp_out_queue.sv
// two-entry result queue between the compute stage and the output stream
module lbmp_out_queue #(
  parameter int WIDTH = 44
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data,
  output logic [1:0]       count
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count_next;

  assign head_valid = (count != 2'd0);
  assign head_data  = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (!push && pop) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && count == 2'd2) |-> pop)
    else $error("result pushed into a full queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("queue count out of range");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from an empty queue");

endmodule

FILE: tb/sv/tb_top.sv
// self-checking testbench for line_buffer_max_pool: predicts every window maximum beat by beat
module tb_top
  import lbmp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SBITS   = SAMPLE_BITS_DEF;
  localparam int WIN     = WINDOW_DIM_DEF;
  localparam int N_COLS  = MAX_COLUMNS_DEF;
  localparam int N_PAIRS = PAIRS_DEF;
  localparam int TDATA_W = ((2*SBITS + SIDE_BITS + 7) / 8) * 8;

  localparam logic REQ_REAL = 1'b0;
  localparam logic REQ_PAD  = 1'b1;
  localparam logic signed [SBITS-1:0] PAD_SAMPLE = -(2**(SBITS-1) - 1);

  localparam int RANDOM_ITEMS  = 200;
  localparam int SETTLE_CYCLES = 6;
  localparam int TAIL_CYCLES   = 8;
  localparam int CYCLE_LIMIT   = 500000;

  typedef enum {PAD_EDGES, PAD_RANDOM, PAD_NONE} pad_layout_t;

  typedef struct {
    logic                    kind;
    logic signed [SBITS-1:0] a;
    logic signed [SBITS-1:0] b;
    logic [3:0]              keep;
    logic [3:0]              strb;
    logic                    user;
    logic                    ident;
    logic                    route;
  } slot_t;

  typedef struct {
    logic signed [SBITS-1:0] max_a;
    logic signed [SBITS-1:0] max_b;
    logic [3:0]              keep;
    logic [3:0]              strb;
    logic                    user;
    logic                    ident;
    logic                    route;
    logic                    frame_end;
  } pool_result_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]       cfg_data;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  // value_a, value_b, keep_in, strobe_in, user_in, ident_in, route_in, zero fill
  logic [TDATA_W-1:0]        s_axis_tdata;
  // req_type
  logic                      s_axis_tuser;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  // max_a, max_b, keep_out, strobe_out, user_out, ident_out, route_out, zero fill
  logic [TDATA_W-1:0]        m_axis_tdata;
  // frame_end
  logic                      m_axis_tlast;

  line_buffer_max_pool dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #4 clk = ~clk;

  // pool predictor state
  logic signed [SBITS-1:0] line_a [N_PAIRS][N_COLS][WIN];
  logic signed [SBITS-1:0] line_b [N_PAIRS][N_COLS][WIN];
  int          scan_row = 0;
  int          scan_col = 0;
  int          pair_idx = 0;
  logic [10:0] side_hold = '0;
  int          cfg_in_w = 64;
  int          cfg_in_h = 64;
  int          cfg_out_w = 32;
  int          cfg_out_h = 32;
  int          cfg_stride = 2;

  pool_result_t pending_maxima[$];

  int  fail_count = 0;
  int  cycle_count = 0;
  bit  tx_idle = 1'b1;
  bit  rx_idle = 1'b1;
  int  rx_hold = 0;

  function automatic int eff_stride();
    return (cfg_stride == 0) ? 1 : cfg_stride;
  endfunction

  // shift one slot into the line store and queue the window maximum it completes
  function automatic void advance_scan(input slot_t s);
    logic signed [SBITS-1:0] va, vb, ma, mb;
    pool_result_t res;
    int st, col_lim, row_lim, addr, ca;
    st = eff_stride();
    col_lim = cfg_out_w * st;
    row_lim = cfg_out_h * st;
    addr = scan_col % N_COLS;
    if (s.kind == REQ_REAL) begin
      va = s.a;
      vb = s.b;
      side_hold = {s.route, s.ident, s.user, s.strb, s.keep};
    end else begin
      va = PAD_SAMPLE;
      vb = PAD_SAMPLE;
    end
    for (int i = 0; i + 1 < WIN; i++) begin
      line_a[pair_idx][addr][i] = line_a[pair_idx][addr][i+1];
      line_b[pair_idx][addr][i] = line_b[pair_idx][addr][i+1];
    end
    line_a[pair_idx][addr][WIN-1] = va;
    line_b[pair_idx][addr][WIN-1] = vb;

    if (scan_row >= WIN - 1 && scan_col >= WIN - 1 &&
        scan_row % st == st - 1 && scan_col % st == st - 1) begin
      // running max starts at the pad level and only moves on a strictly larger sample
      ma = PAD_SAMPLE;
      mb = PAD_SAMPLE;
      for (int c = 0; c < WIN; c++) begin
        ca = (scan_col - (WIN - 1) + c) % N_COLS;
        for (int r = 0; r < WIN; r++) begin
          if (line_a[pair_idx][ca][r] > ma) ma = line_a[pair_idx][ca][r];
          if (line_b[pair_idx][ca][r] > mb) mb = line_b[pair_idx][ca][r];
        end
      end
      res.max_a = ma;
      res.max_b = mb;
      res.keep  = side_hold[3:0];
      res.strb  = side_hold[7:4];
      res.user  = side_hold[8];
      res.ident = side_hold[9];
      res.route = side_hold[10];
      res.frame_end = (scan_row + 1 == row_lim) && (scan_col + 1 == col_lim) &&
                      (pair_idx == N_PAIRS - 1);
      pending_maxima.push_back(res);
    end

    pair_idx++;
    if (pair_idx >= N_PAIRS) begin
      pair_idx = 0;
      scan_col++;
      if (scan_col >= col_lim) begin
        scan_col = 0;
        scan_row++;
        if (scan_row >= row_lim) scan_row = 0;
      end
    end
  endfunction

  task automatic note_mismatch(input string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      note_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    pool_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_maxima.size() == 0) begin
        note_mismatch($sformatf("unexpected beat %h last %b", m_axis_tdata, m_axis_tlast));
      end else begin
        want = pending_maxima.pop_front();
        check_field("max_a", m_axis_tdata[SBITS-1:0], want.max_a);
        check_field("max_b", m_axis_tdata[2*SBITS-1:SBITS], want.max_b);
        check_field("keep", m_axis_tdata[2*SBITS+3:2*SBITS], want.keep);
        check_field("strobe", m_axis_tdata[2*SBITS+7:2*SBITS+4], want.strb);
        check_field("user", m_axis_tdata[2*SBITS+8], want.user);
        check_field("ident", m_axis_tdata[2*SBITS+9], want.ident);
        check_field("route", m_axis_tdata[2*SBITS+10], want.route);
        check_field("frame_end", m_axis_tlast, want.frame_end);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_maxima.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random ready gaps, plus one long hold-off on request
  initial begin : result_sink
    int gap;
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      gap = rx_idle ? $urandom_range(0, 14) : 0;
      @(negedge clk);
      if (rx_hold > 0) begin
        gap = rx_hold;
        rx_hold = 0;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  task automatic send_slot(input slot_t s);
    int gap;
    gap = tx_idle ? $urandom_range(0, 14) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= s.kind;
    s_axis_tdata  <= TDATA_W'({s.route, s.ident, s.user, s.strb, s.keep, s.b, s.a});
    do @(posedge clk); while (!s_axis_tready);
    advance_scan(s);
  endtask

  // sender goes quiet until every queued maximum has come out
  task automatic wait_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_maxima.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_BITS'(val);
    case (idx)
      REG_IN_WIDTH:   cfg_in_w = val & 7'h7f;
      REG_IN_HEIGHT:  cfg_in_h = val & 7'h7f;
      REG_OUT_WIDTH:  cfg_out_w = val & 7'h7f;
      REG_OUT_HEIGHT: cfg_out_h = val & 7'h7f;
      REG_STRIDE:     cfg_stride = val & 2'h3;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // only called at a frame boundary, so every window reads entries of the new frame
  task automatic set_config(input int in_w, input int in_h, input int out_w,
                            input int out_h, input int st);
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_IN_WIDTH, in_w);
    write_reg(REG_IN_HEIGHT, in_h);
    write_reg(REG_OUT_WIDTH, out_w);
    write_reg(REG_OUT_HEIGHT, out_h);
    write_reg(REG_STRIDE, st);
  endtask

  function automatic logic [SBITS-1:0] pick_sample(input bit floor_vals);
    if (floor_vals) return ($urandom_range(0, 7) == 0) ? 16'h8001 : 16'h8000;
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h8001;
      3: return 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic slot_t random_slot(input bit floor_vals);
    slot_t s;
    s.kind  = REQ_REAL;
    s.a     = pick_sample(floor_vals);
    s.b     = pick_sample(floor_vals);
    s.keep  = 4'($urandom);
    s.strb  = 4'($urandom);
    s.user  = 1'($urandom);
    s.ident = 1'($urandom);
    s.route = 1'($urandom);
    return s;
  endfunction

  // one whole frame in row, column, pair order; returns the number of beats sent
  task automatic run_frame(input pad_layout_t layout, input bit floor_vals,
                           output int sent);
    slot_t s;
    int col_lim, row_lim;
    col_lim = cfg_out_w * eff_stride();
    row_lim = cfg_out_h * eff_stride();
    sent = 0;
    for (int r = 0; r < row_lim; r++) begin
      for (int c = 0; c < col_lim; c++) begin
        for (int p = 0; p < N_PAIRS; p++) begin
          s = random_slot(floor_vals);
          case (layout)
            PAD_EDGES:  s.kind = (c >= cfg_in_w || r >= cfg_in_h) ? REQ_PAD : REQ_REAL;
            PAD_RANDOM: s.kind = ($urandom_range(0, 2) == 0) ? REQ_PAD : REQ_REAL;
            default:    s.kind = REQ_REAL;
          endcase
          send_slot(s);
          sent++;
          if ($urandom_range(0, 199) == 0) wait_results();
        end
      end
    end
    wait_results();
  endtask

  // only pads before the first window, so its sideband is the reset value;
  // then a real beat for each other pair on the window corner, most with extreme samples
  task automatic test_reset_sideband();
    slot_t s;
    set_config(1, 1, 1, 1, 2);
    for (int i = 0; i < 4 * N_PAIRS; i++) begin
      s = random_slot(1'b0);
      s.kind = (i <= 3 * N_PAIRS) ? REQ_PAD : REQ_REAL;
      {s.keep, s.strb, s.user, s.ident, s.route} = i[0] ? 11'h7ff : 11'h000;
      case (i % N_PAIRS)
        1: begin s.a = 16'sh8000; s.b = 16'sh8000; end
        2: begin s.a = 16'sh7fff; s.b = 16'sh8001; end
        3: begin s.a = 16'sh0000; s.b = 16'shffff; end
        4: begin s.a = 16'sh8001; s.b = 16'sh7fff; end
        5: begin s.a = 16'sh0001; s.b = 16'sh8000; end
        7: begin s.a = 16'sh7fff; s.b = 16'sh7fff; end
        default: ;
      endcase
      send_slot(s);
    end
    wait_results();
  endtask

  // long scan across many column addresses, the last two columns padded
  task automatic test_wide_columns();
    int n;
    set_config(10, 2, 6, 1, 2);
    run_frame(PAD_EDGES, 1'b0, n);
  endtask

  task automatic test_tall_map();
    int n;
    set_config(1, 6, 2, 8, 1);
    run_frame(PAD_EDGES, 1'b0, n);
  endtask

  // one column and one row: frames wrap without ever closing a window
  task automatic test_single_slot_frames();
    int n;
    set_config(64, 64, 1, 1, 1);
    run_frame(PAD_NONE, 1'b0, n);
    run_frame(PAD_RANDOM, 1'b0, n);
  endtask

  task automatic test_output_backpressure();
    int n;
    set_config(4, 2, 4, 2, 1);
    tx_idle = 1'b0;
    rx_hold = 300;
    run_frame(PAD_EDGES, 1'b0, n);
    tx_idle = 1'b1;
  endtask

  task automatic test_random_frames();
    int total, n, st, ow, oh, pick;
    pad_layout_t layout;
    total = 0;
    while (total < RANDOM_ITEMS) begin
      st = $urandom_range(1, 2);
      ow = $urandom_range(1, (st == 1) ? 4 : 3);
      oh = $urandom_range(1, (st == 1) ? 4 : 3);
      set_config($urandom_range(1, ow * st), $urandom_range(1, oh * st), ow, oh, st);
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 19);
      layout = (pick < 15) ? PAD_EDGES : (pick < 18) ? PAD_RANDOM : PAD_NONE;
      run_frame(layout, $urandom_range(0, 7) == 0, n);
      total += n;
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_IN_WIDTH;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_REAL;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_sideband();
    test_wide_columns();
    test_tall_map();
    test_single_slot_frames();
    test_output_backpressure();
    test_random_frames();

    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_maxima.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", pending_maxima.size()));
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
